// ===== hw/rtl/swmd_pkg.sv =====
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared types and codes for the stack with middle delete: item structs,
// operation and status codes, controller to datapath command and status.
// ----------------------------------------------------------------------------
package swmd_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_DELMID = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam int unsigned CountOutWidth = 7;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]       removed_value;
    logic signed [31:0]       top_value;
    logic signed [31:0]       middle_value;
    logic [CountOutWidth-1:0] entry_count;
    logic [1:0]               status;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch a new item
    logic set_ovf;
    logic set_unf;
    logic push;        // write pushed value at count, count up
    logic dec_occ;     // count down
    logic rd_mid;      // read port a at the middle position
    logic rd_next;     // read port a at shift index plus one
    logic idx_load;    // shift index starts at the middle
    logic wr_shift;    // move the entry read last cycle down one place
    logic cap_removed; // keep read port a data as the removed value
    logic out_valid;
  } ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       shift_done;
  } sts_t;

endpackage

// ===== hw/rtl/swmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// swmd_ctrl
// Controller state machine: sequences push, pop, delete-middle with its
// entry-by-entry shift, and the final read of top and middle.
// ----------------------------------------------------------------------------
module swmd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  swmd_pkg::sts_t sts,
  output swmd_pkg::ctl_t ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PCAPT = 3'd2;
  localparam logic [2:0] S_DCAPT = 3'd3;
  localparam logic [2:0] S_SHRD  = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_RDOUT = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE) && (state_r != S_DONE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RDOUT;
        case (sts.op)
          swmd_pkg::OP_PUSH: begin
            if (sts.full) begin
              ctl.set_ovf = 1'b1;
            end else begin
              ctl.push = 1'b1;
            end
          end
          swmd_pkg::OP_POP: begin
            if (sts.empty) begin
              ctl.set_unf = 1'b1;
            end else begin
              // port a reads the top before the count drops
              ctl.dec_occ = 1'b1;
              state_nxt   = S_PCAPT;
            end
          end
          swmd_pkg::OP_DELMID: begin
            if (sts.empty) begin
              ctl.set_unf = 1'b1;
            end else begin
              ctl.rd_mid   = 1'b1;
              ctl.idx_load = 1'b1;
              state_nxt    = S_DCAPT;
            end
          end
          default: begin
            state_nxt = S_RDOUT;
          end
        endcase
      end
      S_PCAPT: begin
        ctl.cap_removed = 1'b1;
        state_nxt       = S_RDOUT;
      end
      S_DCAPT: begin
        ctl.cap_removed = 1'b1;
        state_nxt       = S_SHRD;
      end
      S_SHRD: begin
        if (sts.shift_done) begin
          ctl.dec_occ = 1'b1;
          state_nxt   = S_RDOUT;
        end else begin
          ctl.rd_next = 1'b1;
          state_nxt   = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl.wr_shift = 1'b1;
        state_nxt    = S_SHRD;
      end
      S_RDOUT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.out_valid = 1'b1;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/swmd_dpath.sv =====
// ----------------------------------------------------------------------------
// swmd_dpath
// Datapath: entry memory with one write and two registered read ports,
// entry count, shift index, item and result registers.
// ----------------------------------------------------------------------------
module swmd_dpath #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swmd_pkg::in_item_t  in_item,
  input  swmd_pkg::ctl_t      ctl,
  output swmd_pkg::sts_t      sts,
  output swmd_pkg::out_item_t out_item
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned OW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW = swmd_pkg::CountOutWidth;

  logic signed [31:0] mem [STACK_DEPTH];

  logic [1:0]         op_r, op_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] removed_r, removed_nxt;
  logic [1:0]         status_r, status_nxt;
  logic signed [31:0] rd_a_r, rd_b_r;

  logic [OW-1:0]      occ_m1;
  logic [OW-1:0]      idx_p1;
  logic [AW-1:0]      top_addr;
  logic [AW-1:0]      mid_addr;
  logic [AW-1:0]      raddr_a;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [OW+CW-1:0]   occ_wide;

  assign occ_m1   = occ_r - OW'(1);
  assign idx_p1   = OW'(idx_r) + OW'(1);
  assign top_addr = occ_m1[AW-1:0];
  assign mid_addr = AW'(occ_r >> 1);

  always_comb begin
    if (ctl.rd_mid) begin
      raddr_a = mid_addr;
    end else if (ctl.rd_next) begin
      raddr_a = idx_p1[AW-1:0];
    end else begin
      raddr_a = top_addr;
    end
  end

  assign we    = ctl.push | ctl.wr_shift;
  assign waddr = ctl.push ? occ_r[AW-1:0] : idx_r;
  assign wdata = ctl.push ? val_r : rd_a_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[mid_addr];
  end

  always_comb begin
    op_nxt      = op_r;
    val_nxt     = val_r;
    occ_nxt     = occ_r;
    idx_nxt     = idx_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    if (ctl.load) begin
      op_nxt      = in_item.operation;
      val_nxt     = in_item.push_value;
      removed_nxt = '0;
      status_nxt  = swmd_pkg::ST_OK;
    end
    if (ctl.set_ovf) begin
      status_nxt = swmd_pkg::ST_OVERFLOW;
    end
    if (ctl.set_unf) begin
      status_nxt = swmd_pkg::ST_UNDERFLOW;
    end
    if (ctl.push) begin
      occ_nxt = occ_r + OW'(1);
    end
    if (ctl.dec_occ) begin
      occ_nxt = occ_m1;
    end
    if (ctl.idx_load) begin
      idx_nxt = mid_addr;
    end
    if (ctl.wr_shift) begin
      idx_nxt = idx_p1[AW-1:0];
    end
    if (ctl.cap_removed) begin
      removed_nxt = rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  assign sts.op         = op_r;
  assign sts.empty      = (occ_r == '0);
  assign sts.full       = (occ_r == OW'(STACK_DEPTH));
  assign sts.shift_done = (idx_p1 >= occ_r);

  assign occ_wide = (OW+CW)'(occ_r);

  assign out_item.removed_value = removed_r;
  assign out_item.top_value     = (occ_r != '0) ? rd_a_r : 32'sd0;
  assign out_item.middle_value  = (occ_r != '0) ? rd_b_r : 32'sd0;
  assign out_item.entry_count   = occ_wide[CW-1:0];
  assign out_item.status        = status_r;

endmodule

// ===== hw/rtl/stack_with_middle_delete.sv =====
// ----------------------------------------------------------------------------
// stack_with_middle_delete
// Bounded stack of signed 32-bit values with push, pop and delete-middle.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with out_strobe, and the receiver cannot stall
// it. Push, a failed request or an unused code pass through the execute and
// output read states; pop adds a capture state, and delete-middle adds a
// capture state and a read and a write state for each of the k = count - 1 -
// floor(count/2) entries that move down, since the entry memory moves one
// entry at a time through its single write port. busy drops in the cycle
// the result is shown, so the next item can be taken on that edge. Middle is
// the entry at floor(count/2) from the bottom; top and middle read 0 when the
// stack is empty, and a full push or an empty pop or delete leaves the stack
// unchanged and reports overflow or underflow.
// ----------------------------------------------------------------------------
module stack_with_middle_delete #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  swmd_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output swmd_pkg::out_item_t out_item
);

  swmd_pkg::ctl_t ctl;
  swmd_pkg::sts_t sts;

  swmd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  swmd_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctl      (ctl),
    .sts      (sts),
    .out_item (out_item)
  );

  assign out_strobe = ctl.out_valid;

endmodule
